[src/bfdf_pkg.sv]
package bfdf_pkg;

  localparam int unsigned WidthDefault  = 84;
  localparam int unsigned HeightDefault = 48;
  localparam int unsigned BanksDefault  = 6;

  localparam logic [7:0] CMD_SET_Y = 8'h40;
  localparam logic [7:0] CMD_SET_X = 8'h80;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_SET_Y = 2'd0,
    PH_SET_X = 2'd1,
    PH_DATA  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WORK  = 2'd2
  } state_e;

endpackage

[src/banked_framebuffer_dirty_flush.sv]
// Banked monochrome frame store of BANKS x WIDTH column bytes (bit 0 on top) with a
// dirty rectangle and a byte-serial flush. Each request is a draw, a clear or a flush
// tick and gives exactly one response; a flush tick response carries the next panel
// byte, if any (per dirty bank: set-Y command, set-X command, then data bytes) with
// its D/C level. Draw and flush requests do one store read, then the modify, write
// back and response. A clear also starts a sweep over all WIDTH*BANKS entries (504
// at the defaults) that writes the store to zero, one entry a cycle through the
// single write port; the same sweep runs after reset, and no request is accepted
// while it runs.
module banked_framebuffer_dirty_flush
  import bfdf_pkg::*;
#(
  parameter int unsigned WIDTH  = WidthDefault,
  parameter int unsigned HEIGHT = HeightDefault,
  parameter int unsigned BANKS  = BanksDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  input  logic       ink_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic       dc_level_o,
  output logic       flush_last_o,
  output logic       range_error_o
);

  localparam int unsigned Depth = WIDTH * BANKS;
  localparam int unsigned AddrW = $clog2(Depth);

  state_e state_q, state_d;
  logic   in_accept;
  logic   work;

  logic [AddrW-1:0] sweep_q, sweep_d;
  logic             sweep_done;

  logic [1:0] op_q;
  logic [7:0] x_q, y_q;
  logic       ink_q;
  logic [AddrW-1:0] addr_q;

  logic [6:0] xmin_q, xmin_d, xmax_q, xmax_d;
  logic [5:0] ymin_q, ymin_d, ymax_q, ymax_d;
  logic       act_q, act_d;
  logic [2:0] bank_q, bank_d;
  logic [6:0] col_q, col_d;
  phase_e     phase_q, phase_d;

  logic       out_valid_q;
  logic       bvalid_q, bvalid_d;
  logic [7:0] byte_q, byte_d;
  logic       dc_q, dc_d;
  logic       last_q, last_d;
  logic       err_q, err_d;

  logic [AddrW-1:0] draw_addr, flush_addr, raddr, waddr;
  logic [7:0]       rdata, wdata, draw_wdata, bit_mask;
  logic             mem_we, draw_we;
  logic [2:0]       flush_bank_c, last_bank;
  logic [6:0]       flush_col_c;
  logic             draw_err;

  always_comb begin
    flush_bank_c = (bank_q > 3'(BANKS - 1)) ? 3'(BANKS - 1) : bank_q;
    flush_col_c  = (col_q > 7'(WIDTH - 1)) ? 7'(WIDTH - 1) : col_q;
    draw_addr    = AddrW'(32'(pixel_y_i[7:3]) * 32'(WIDTH) + 32'(pixel_x_i));
    flush_addr   = AddrW'(32'(flush_bank_c) * 32'(WIDTH) + 32'(flush_col_c));
    raddr        = (opcode_i == OP_DRAW) ? draw_addr : flush_addr;
    last_bank    = (ymax_q[5:3] > 3'(BANKS - 1)) ? 3'(BANKS - 1) : ymax_q[5:3];
    draw_err     = (x_q >= 8'(WIDTH)) || (y_q >= 8'(HEIGHT)) || (y_q[7:3] >= 5'(BANKS));
    bit_mask     = 8'(1) << y_q[2:0];
    sweep_done   = (sweep_q == AddrW'(Depth - 1));
  end

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    in_stall_o = 1'b1;
    work       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_done ? '0 : sweep_q + AddrW'(1);
        if (sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        if (in_valid_i && !in_stall_o) begin
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        work    = 1'b1;
        state_d = (op_q == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    xmin_d     = xmin_q;
    xmax_d     = xmax_q;
    ymin_d     = ymin_q;
    ymax_d     = ymax_q;
    act_d      = act_q;
    bank_d     = bank_q;
    col_d      = col_q;
    phase_d    = phase_q;
    bvalid_d   = 1'b0;
    byte_d     = '0;
    dc_d       = 1'b0;
    last_d     = 1'b0;
    err_d      = 1'b0;
    draw_we    = 1'b0;
    draw_wdata = ink_q ? (rdata | bit_mask) : (rdata & ~bit_mask);
    case (op_q)
      OP_DRAW: begin
        if (draw_err) begin
          err_d = 1'b1;
        end else begin
          draw_we = 1'b1;
          if (x_q[6:0] < xmin_q) xmin_d = x_q[6:0];
          if (x_q[6:0] > xmax_q) xmax_d = x_q[6:0];
          if (y_q[5:0] < ymin_q) ymin_d = y_q[5:0];
          if (y_q[5:0] > ymax_q) ymax_d = y_q[5:0];
        end
      end
      OP_CLEAR: begin
        xmin_d  = '0;
        xmax_d  = 7'(WIDTH - 1);
        ymin_d  = '0;
        ymax_d  = 6'(HEIGHT - 1);
        act_d   = 1'b0;
        bank_d  = '0;
        col_d   = '0;
        phase_d = PH_SET_Y;
      end
      OP_FLUSH: begin
        if (!act_q && (xmin_q <= xmax_q) && (ymin_q <= ymax_q)) begin
          act_d   = 1'b1;
          bank_d  = (ymin_q[5:3] > 3'(BANKS - 1)) ? 3'(BANKS - 1) : ymin_q[5:3];
          col_d   = '0;
          phase_d = PH_SET_Y;
        end
        if (act_d) begin
          bvalid_d = 1'b1;
          case (phase_d)
            PH_SET_Y: begin
              byte_d  = CMD_SET_Y | {5'b0, bank_d};
              phase_d = PH_SET_X;
            end
            PH_SET_X: begin
              byte_d  = CMD_SET_X | {1'b0, xmin_q};
              col_d   = xmin_q;
              phase_d = PH_DATA;
            end
            default: begin
              byte_d = rdata;
              dc_d   = 1'b1;
              if (col_q >= xmax_q) begin
                if (bank_q >= last_bank) begin
                  last_d  = 1'b1;
                  act_d   = 1'b0;
                  phase_d = PH_SET_Y;
                  bank_d  = '0;
                  col_d   = '0;
                  xmin_d  = 7'(WIDTH - 1);
                  xmax_d  = '0;
                  ymin_d  = 6'(HEIGHT - 1);
                  ymax_d  = '0;
                end else begin
                  bank_d  = bank_q + 3'd1;
                  phase_d = PH_SET_Y;
                end
              end else begin
                col_d = col_q + 7'd1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = addr_q;
    wdata  = draw_wdata;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      waddr  = sweep_q;
      wdata  = '0;
    end else if (work) begin
      mem_we = draw_we;
    end
  end

  bfdf_ram #(
    .DataW(8),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= opcode_i;
      x_q    <= pixel_x_i;
      y_q    <= pixel_y_i;
      ink_q  <= ink_i;
      addr_q <= draw_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q  <= 7'(WIDTH - 1);
      xmax_q  <= '0;
      ymin_q  <= 6'(HEIGHT - 1);
      ymax_q  <= '0;
      act_q   <= 1'b0;
      bank_q  <= '0;
      col_q   <= '0;
      phase_q <= PH_SET_Y;
    end else if (work) begin
      xmin_q  <= xmin_d;
      xmax_q  <= xmax_d;
      ymin_q  <= ymin_d;
      ymax_q  <= ymax_d;
      act_q   <= act_d;
      bank_q  <= bank_d;
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (work) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      bvalid_q <= bvalid_d;
      byte_q   <= byte_d;
      dc_q     <= dc_d;
      last_q   <= last_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_valid_o  = bvalid_q;
  assign out_byte_o    = byte_q;
  assign dc_level_o    = dc_q;
  assign flush_last_o  = last_q;
  assign range_error_o = err_q;

endmodule

[src/bfdf_ram.sv]
module bfdf_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 504,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/bfdf_checker.sv]
module bfdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       byte_valid_o,
  input logic [7:0] out_byte_o,
  input logic       dc_level_o,
  input logic       flush_last_o,
  input logic       range_error_o
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_valid_o) && $stable(flush_last_o))
    else $error("stalled response changed");

  a_quiet_when_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0 && !dc_level_o && !flush_last_o)
    else $error("idle response carries byte fields");

  a_error_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> !byte_valid_o)
    else $error("range error with panel byte");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_last_o |-> byte_valid_o && dc_level_o)
    else $error("final flush byte is not data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in progress");

endmodule

bind banked_framebuffer_dirty_flush bfdf_checker u_bfdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .byte_valid_o (byte_valid_o),
  .out_byte_o   (out_byte_o),
  .dc_level_o   (dc_level_o),
  .flush_last_o (flush_last_o),
  .range_error_o(range_error_o)
);
